/* design/power_iteration_centrality_unit_macros.svh */
// ----------------------------------------------------------------------------
// Power iteration centrality assertion macros
// Concurrent checks for the centrality unit; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef POWER_ITERATION_CENTRALITY_UNIT_MACROS_SVH
`define POWER_ITERATION_CENTRALITY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PIC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pic: same-cycle check failed");
`define PIC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pic: next-cycle check failed");
`else
`define PIC_ASSERT_IMP(label, clk, rst, ante, cons)
`define PIC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/pic_pkg.sv */
// ----------------------------------------------------------------------------
// Power iteration centrality package
// Beat types, operation codes and register indexes shared by the unit.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
  localparam logic [1:0] OP_LOAD_START = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 2'd2;

  localparam logic [6:0]  VERTEX_COUNT_RST = 7'd64;
  localparam logic [31:0] THRESHOLD_RST    = 32'd4;
  localparam logic [7:0]  ITER_LIMIT_RST   = 8'd101;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  index;
    logic [63:0] adjacency_row;
    logic [15:0] start_value;
  } pic_cmd_t;

  typedef struct packed {
    logic [5:0]  vertex;
    logic [31:0] score;
    logic [31:0] eigenvalue;
    logic [7:0]  iterations;
    logic        converged;
    logic        last;
  } pic_res_t;

  typedef struct packed {
    logic start;
    logic sqrt;
  } pic_unit_cmd_t;

endpackage

/* design/pic_sqdiv.sv */
// ----------------------------------------------------------------------------
// Shared square root and divide unit
// Restoring digit recurrence: two source bits a step for the root, one for the
// quotient, through one shared compare and subtract.
// ----------------------------------------------------------------------------
module pic_sqdiv import pic_pkg::*; #(
  parameter int VW        = 38,
  parameter int DIV_STEPS = 70
) (
  input  logic                clk,
  input  logic                rst,
  input  pic_unit_cmd_t       cmd,
  input  logic [2*VW-1:0]     src,
  input  logic [VW-1:0]       divisor,
  output logic [VW-1:0]       result,
  output logic                done
);

  localparam int SW  = 2 * VW;
  localparam int RMW = VW + 3;
  localparam int CNW = $clog2(DIV_STEPS + 1);

  logic            busy;
  logic            mode_sqrt;
  logic [CNW-1:0]  cnt;
  logic [SW-1:0]   src_sh;
  logic [RMW-1:0]  rem;
  logic [VW-1:0]   res;
  logic [RMW-1:0]  rem_sh;
  logic [RMW-1:0]  trial;
  logic [RMW:0]    diff;
  logic            take;

  always_comb begin
    if (mode_sqrt) begin
      rem_sh = {rem[RMW-3:0], src_sh[SW-1:SW-2]};
      trial  = RMW'({res, 2'b01});
    end else begin
      rem_sh = {rem[RMW-2:0], src_sh[SW-1]};
      trial  = RMW'(divisor);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    take = !diff[RMW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_sqrt <= cmd.sqrt;
      src_sh    <= src;
      rem       <= '0;
      res       <= '0;
      cnt       <= cmd.sqrt ? CNW'(VW) : CNW'(DIV_STEPS);
    end else if (busy) begin
      rem    <= take ? diff[RMW-1:0] : rem_sh;
      res    <= {res[VW-2:0], take};
      src_sh <= mode_sqrt ? (src_sh << 2) : (src_sh << 1);
      cnt    <= cnt - CNW'(1);
    end
  end

  assign result = res;

endmodule

/* design/power_iteration_centrality_unit.sv */
// ----------------------------------------------------------------------------
// Power iteration centrality unit
// Eigenvector centrality of an adjacency bit matrix by power iteration.
// ----------------------------------------------------------------------------
// Usage: command beats on cmd_* load adjacency rows (op 0) and start elements
// (op 1), one beat per cycle, no result. A run beat (op 2) drops cmd_ready
// until the run is over; the run then sends one result beat per vertex in use
// on res_*, vertex 0 first, last set on the final one. Register writes go on
// cfg_* (always ready); the user must make them only while the unit is idle,
// which the unit itself does not enforce.
// Vector elements are VW = SCORE_BITS + 6 bits wide. In a run of I iterations,
// each normalization sums the squares by shift-add squaring, then takes the
// square root and divides every element in the shared root/divide unit; each
// matrix product goes element by element through the vector memory, and each
// iteration then computes the eigenvalue and convergence check. A run does
// (I+1) normalizations and I products, then sends the result beats.
// A stalled receiver holds the current result beat; the unit waits for it.
// Reset clears registers to their defaults and the adjacency rows to no edges
// through per-row valid bits; start elements are undefined until loaded.
// ----------------------------------------------------------------------------
`include "power_iteration_centrality_unit_macros.svh"

module power_iteration_centrality_unit import pic_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int SCORE_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  pic_cmd_t             cmd_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pic_res_t             res_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int F    = SCORE_BITS - 1;
  localparam int VW   = SCORE_BITS + 6;
  localparam int SW   = 2 * VW;
  localparam int NW   = VW + F + 1;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int ESH  = F - 24;
  localparam int EL   = (ESH > 0) ? ESH : 0;
  localparam int ER   = (ESH < 0) ? -ESH : 0;
  localparam int EWW  = (VW + ER > 33) ? VW + ER : 33;
  localparam int SSH  = F - 31;
  localparam int SL   = (SSH > 0) ? SSH : 0;
  localparam int SR   = (SSH < 0) ? -SSH : 0;
  localparam int SWW  = (VW + SR > 32) ? VW + SR : 32;
  localparam int VDEP = 2 ** (IW + 1);

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_SQ_RD    = 19'h00002,
    S_SQ_LD    = 19'h00004,
    S_SQ_MUL   = 19'h00008,
    S_SQRT     = 19'h00010,
    S_DV_RD    = 19'h00020,
    S_DV_LD    = 19'h00040,
    S_DV_RUN   = 19'h00080,
    S_MV_ROW   = 19'h00100,
    S_MV_ROWLD = 19'h00200,
    S_MV_RD    = 19'h00400,
    S_MV_ACC   = 19'h00800,
    S_MV_WR    = 19'h01000,
    S_EIG      = 19'h02000,
    S_CONV_MUL = 19'h04000,
    S_CONV_CMP = 19'h08000,
    S_OUT_RD   = 19'h10000,
    S_OUT_LD   = 19'h20000,
    S_OUT_HOLD = 19'h40000
  } state_t;

  state_t              state;
  logic [6:0]          vertex_count;
  logic [31:0]         threshold;
  logic [7:0]          iter_limit;
  logic [IW-1:0]       n_last;
  logic                cur;
  logic                first;
  logic [IW-1:0]       i;
  logic [IW-1:0]       j;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       sq_a;
  logic [VW-1:0]       sq_b;
  logic [VW-1:0]       r;
  logic [VW-1:0]       acc;
  logic [MAX_VERTICES-1:0] rowbits;
  logic [31:0]         eig;
  logic [31:0]         prior;
  logic [7:0]          iter;
  logic                conv;
  logic [63:0]         prod;
  logic [31:0]         diffr;
  pic_res_t            res_q;
  logic                res_v;

  logic [VW-1:0]           vmem [VDEP];
  logic [VW-1:0]           vq;
  logic                    v_we;
  logic [IW:0]             v_wa;
  logic [VW-1:0]           v_wd;
  logic                    v_re;
  logic [IW:0]             v_ra;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] adj_q;
  logic                    adj_v;
  logic                    adj_we;

  pic_unit_cmd_t       u_cmd;
  logic [SW-1:0]       u_src;
  logic [VW-1:0]       u_res;
  logic                u_done;
  logic [NW-1:0]       num;
  logic [VW-1:0]       quot;
  logic [EWW-1:0]      ew;
  logic [31:0]         eig_next;
  logic [SWW-1:0]      sw;
  logic                cmd_acc;
  logic                idx_ok;
  logic [IW-1:0]       n_last_next;

  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign idx_ok    = ({1'b0, cmd_data.index} < 7'(MAX_VERTICES));
  assign res_valid = res_v;
  assign res_data  = res_q;

  always_comb begin
    if (vertex_count == 7'd0) begin
      n_last_next = '0;
    end else if (vertex_count >= 7'(MAX_VERTICES)) begin
      n_last_next = IW'(MAX_VERTICES - 1);
    end else begin
      n_last_next = IW'(vertex_count - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
      threshold    <= THRESHOLD_RST;
      iter_limit   <= ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count <= cfg_data[6:0];
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_ITER_LIMIT:   iter_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // vector memory: bank 0 holds the working vector, bank 1 the product
  always_comb begin
    v_we = 1'b0;
    v_wa = {1'b0, i};
    v_wd = '0;
    v_re = 1'b0;
    v_ra = {cur, i};
    quot = (u_res > (VW'(1) << F)) ? (VW'(1) << F) : u_res;
    case (state)
      S_IDLE: begin
        v_we = cmd_acc && cmd_data.op == OP_LOAD_START && idx_ok;
        v_wa = {1'b0, cmd_data.index[IW-1:0]};
        v_wd = VW'(cmd_data.start_value);
      end
      S_SQ_RD, S_DV_RD: v_re = 1'b1;
      S_OUT_RD: begin
        v_re = 1'b1;
        v_ra = {1'b0, i};
      end
      S_MV_RD: begin
        v_re = 1'b1;
        v_ra = {1'b0, j};
      end
      S_DV_LD: v_we = (r == '0);
      S_DV_RUN: begin
        v_we = u_done;
        v_wd = quot;
      end
      S_MV_WR: begin
        v_we = 1'b1;
        v_wa = {1'b1, i};
        v_wd = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    if (v_re) begin
      vq <= vmem[v_ra];
    end
  end

  assign adj_we = cmd_acc && cmd_data.op == OP_LOAD_ROW && idx_ok;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[cmd_data.index[IW-1:0]] <= cmd_data.adjacency_row[MAX_VERTICES-1:0];
    end
    if (state == S_MV_ROW) begin
      adj_q <= adj_mem[i];
      adj_v <= row_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (adj_we) begin
      row_valid[cmd_data.index[IW-1:0]] <= 1'b1;
    end
  end

  // shared root/divide unit
  always_comb begin
    num          = (NW'(vq) << F) + NW'(r >> 1);
    u_cmd.start  = 1'b0;
    u_cmd.sqrt   = 1'b0;
    u_src        = {num, (SW - NW)'(0)};
    if (state == S_SQ_MUL && sq_b == '0 && i == n_last) begin
      u_cmd.start = 1'b1;
      u_cmd.sqrt  = 1'b1;
      u_src       = sum;
    end else if (state == S_DV_LD && r != '0) begin
      u_cmd.start = 1'b1;
    end
  end

  pic_sqdiv #(
    .VW        (VW),
    .DIV_STEPS (NW)
  ) u_sqdiv (
    .clk     (clk),
    .rst     (rst),
    .cmd     (u_cmd),
    .src     (u_src),
    .divisor (r),
    .result  (u_res),
    .done    (u_done)
  );

  always_comb begin
    ew       = (EWW'(r) >> EL) << ER;
    eig_next = (|ew[EWW-1:32]) ? 32'hFFFF_FFFF : ew[31:0];
    sw       = (SWW'(vq) >> SL) << SR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= 1'b0;
      first <= 1'b0;
      res_v <= 1'b0;
      i     <= '0;
      j     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_acc && cmd_data.op == OP_RUN) begin
            n_last <= n_last_next;
            cur    <= 1'b0;
            first  <= 1'b1;
            conv   <= 1'b0;
            prior  <= '0;
            iter   <= '0;
            i      <= '0;
            sum    <= '0;
            state  <= S_SQ_RD;
          end
        end
        S_SQ_RD: state <= S_SQ_LD;
        S_SQ_LD: begin
          sq_a  <= SW'(vq);
          sq_b  <= vq;
          state <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          if (sq_b == '0) begin
            if (i == n_last) begin
              state <= S_SQRT;
            end else begin
              i     <= i + IW'(1);
              state <= S_SQ_RD;
            end
          end else begin
            if (sq_b[0]) begin
              sum <= sum + sq_a;
            end
            sq_a <= sq_a << 1;
            sq_b <= sq_b >> 1;
          end
        end
        S_SQRT: begin
          if (u_done) begin
            r     <= u_res;
            i     <= '0;
            state <= S_DV_RD;
          end
        end
        S_DV_RD: state <= S_DV_LD;
        S_DV_LD: begin
          if (r != '0) begin
            state <= S_DV_RUN;
          end else if (i != n_last) begin
            i     <= i + IW'(1);
            state <= S_DV_RD;
          end else begin
            i     <= '0;
            first <= 1'b0;
            state <= first ? S_MV_ROW : S_EIG;
          end
        end
        S_DV_RUN: begin
          if (u_done) begin
            if (i != n_last) begin
              i     <= i + IW'(1);
              state <= S_DV_RD;
            end else begin
              i     <= '0;
              first <= 1'b0;
              state <= first ? S_MV_ROW : S_EIG;
            end
          end
        end
        S_MV_ROW: state <= S_MV_ROWLD;
        S_MV_ROWLD: begin
          rowbits <= adj_v ? adj_q : '0;
          acc     <= '0;
          j       <= '0;
          state   <= S_MV_RD;
        end
        S_MV_RD: state <= S_MV_ACC;
        S_MV_ACC: begin
          if (rowbits[j]) begin
            acc <= acc + vq;
          end
          if (j == n_last) begin
            state <= S_MV_WR;
          end else begin
            j     <= j + IW'(1);
            state <= S_MV_RD;
          end
        end
        S_MV_WR: begin
          if (i == n_last) begin
            cur   <= 1'b1;
            i     <= '0;
            sum   <= '0;
            state <= S_SQ_RD;
          end else begin
            i     <= i + IW'(1);
            state <= S_MV_ROW;
          end
        end
        S_EIG: begin
          eig   <= eig_next;
          iter  <= iter + 8'd1;
          state <= S_CONV_MUL;
        end
        S_CONV_MUL: begin
          prod  <= 64'(threshold) * 64'(eig);
          diffr <= (eig > prior) ? eig - prior : prior - eig;
          state <= S_CONV_CMP;
        end
        S_CONV_CMP: begin
          i <= '0;
          if (eig != '0 && {diffr, 32'd0} < prod) begin
            conv  <= 1'b1;
            state <= S_OUT_RD;
          end else begin
            prior <= eig;
            state <= (iter < iter_limit) ? S_MV_ROW : S_OUT_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          res_q.vertex     <= 6'(i);
          res_q.score      <= sw[31:0];
          res_q.eigenvalue <= eig;
          res_q.iterations <= iter;
          res_q.converged  <= conv;
          res_q.last       <= (i == n_last);
          res_v            <= 1'b1;
          state            <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (res_ready) begin
            res_v <= 1'b0;
            if (i == n_last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + IW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PIC_ASSERT_IMP(a_busy_with_result, clk, rst, res_valid, !cmd_ready)
  `PIC_ASSERT_NXT(a_idle_after_last, clk, rst, res_valid && res_ready && res_data.last, cmd_ready)
  `PIC_ASSERT_NXT(a_run_holds_off, clk, rst, cmd_acc && cmd_data.op == OP_RUN, !cmd_ready && !res_valid)

endmodule
